// File: hdl/sd_pkg.sv
package sd_pkg;

   localparam int COUNT_WIDTH_DEFAULT  = 32;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int THRESHOLD_WIDTH      = 16;
   localparam int INDEX_WIDTH          = 3;
   localparam int OUT_WIDTH            = 32;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_STARTED = 3'b010,
      PH_PEAK    = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_SLOW    = 2'd1,
      KIND_WALK    = 2'd2,
      KIND_RUN     = 2'd3
   } kind_type;

   typedef enum logic [INDEX_WIDTH-1:0] {
      REG_SLOW_LOW  = 3'd0,
      REG_SLOW_HIGH = 3'd1,
      REG_WALK_LOW  = 3'd2,
      REG_WALK_HIGH = 3'd3,
      REG_RUN_LOW   = 3'd4,
      REG_RUN_HIGH  = 3'd5
   } reg_index_type;

   localparam logic [THRESHOLD_WIDTH-1:0] SLOW_LOW_RESET  = 16'd1000;
   localparam logic [THRESHOLD_WIDTH-1:0] SLOW_HIGH_RESET = 16'd3000;
   localparam logic [THRESHOLD_WIDTH-1:0] WALK_LOW_RESET  = 16'd2000;
   localparam logic [THRESHOLD_WIDTH-1:0] WALK_HIGH_RESET = 16'd5000;
   localparam logic [THRESHOLD_WIDTH-1:0] RUN_LOW_RESET   = 16'd3000;
   localparam logic [THRESHOLD_WIDTH-1:0] RUN_HIGH_RESET  = 16'd8000;

   localparam logic [7:0] LIMIT_RUN     = 8'd100;
   localparam logic [7:0] LIMIT_WALK    = 8'd120;
   localparam logic [7:0] LIMIT_SLOW    = 8'd130;
   localparam logic [7:0] LIMIT_UNKNOWN = 8'd150;

   typedef struct packed {
      logic [THRESHOLD_WIDTH-1:0] slow_low;
      logic [THRESHOLD_WIDTH-1:0] slow_high;
      logic [THRESHOLD_WIDTH-1:0] walk_low;
      logic [THRESHOLD_WIDTH-1:0] walk_high;
      logic [THRESHOLD_WIDTH-1:0] run_low;
      logic [THRESHOLD_WIDTH-1:0] run_high;
   } thresholds_type;

endpackage

// File: hdl/sd_step.sv
module sd_step
   import sd_pkg::*;
#(
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  thresholds_type              thresholds,
   input  logic [SAMPLE_WIDTH-1:0]     sample,
   input  logic [SAMPLE_WIDTH-1:0]     newest,
   input  logic [SAMPLE_WIDTH-1:0]     middle,
   input  logic [COUNT_WIDTH-1:0]      count,
   input  phase_type                   phase,
   input  logic [COUNT_WIDTH-1:0]      begin_index,
   input  logic [COUNT_WIDTH-1:0]      peak_index,
   input  kind_type                    motion_class,
   input  logic [THRESHOLD_WIDTH-1:0]  lower_limit,
   input  logic [SAMPLE_WIDTH-1:0]     peak_level,
   output logic [COUNT_WIDTH-1:0]      count_in,
   output phase_type                   phase_in,
   output logic [COUNT_WIDTH-1:0]      begin_index_in,
   output logic [COUNT_WIDTH-1:0]      peak_index_in,
   output kind_type                    motion_class_in,
   output logic [THRESHOLD_WIDTH-1:0]  lower_limit_in,
   output logic [SAMPLE_WIDTH-1:0]     peak_level_in,
   output logic                        done,
   output logic [OUT_WIDTH-1:0]        done_start,
   output logic [OUT_WIDTH-1:0]        done_peak,
   output logic [OUT_WIDTH-1:0]        done_end,
   output kind_type                    done_kind
);

   localparam int CMP_WIDTH = (SAMPLE_WIDTH > THRESHOLD_WIDTH) ? SAMPLE_WIDTH : THRESHOLD_WIDTH;

   logic [CMP_WIDTH-1:0]   cur;
   logic [CMP_WIDTH-1:0]   mid;
   logic [CMP_WIDTH-1:0]   old;
   logic [CMP_WIDTH-1:0]   level;
   logic [COUNT_WIDTH-1:0] span;
   logic [COUNT_WIDTH-1:0] end_index;
   logic [7:0]             limit;
   logic                   abort;
   logic                   is_peak;
   logic                   is_rise;
   phase_type              phase_now;
   logic [63:0]            start_wide;
   logic [63:0]            peak_wide;
   logic [63:0]            end_wide;

   assign cur       = CMP_WIDTH'(sample);
   assign mid       = CMP_WIDTH'(newest);
   assign old       = CMP_WIDTH'(middle);
   assign level     = CMP_WIDTH'(peak_level);
   assign count_in  = count + COUNT_WIDTH'(1);
   assign span      = count_in - begin_index;
   assign end_index = count_in - COUNT_WIDTH'(2);
   assign is_peak   = (mid > CMP_WIDTH'(thresholds.slow_high)) && (mid > old) && (mid > cur);
   assign is_rise   = (old < mid) && (mid < cur);

   always_comb begin
      case (motion_class)
         KIND_RUN:  limit = LIMIT_RUN;
         KIND_WALK: limit = LIMIT_WALK;
         KIND_SLOW: limit = LIMIT_SLOW;
         default:   limit = LIMIT_UNKNOWN;
      endcase
   end

   assign abort = ((phase == PH_STARTED) || (phase == PH_PEAK)) &&
                  (span > COUNT_WIDTH'(limit));

   always_comb begin
      phase_now       = phase;
      begin_index_in  = begin_index;
      peak_index_in   = peak_index;
      motion_class_in = motion_class;
      lower_limit_in  = lower_limit;
      peak_level_in   = peak_level;
      done            = 1'b0;
      if (abort) begin
         phase_now       = PH_IDLE;
         begin_index_in  = '0;
         peak_index_in   = '0;
         motion_class_in = KIND_UNKNOWN;
         lower_limit_in  = '0;
      end
      phase_in = phase_now;
      unique case (phase_now)
         PH_STARTED, PH_PEAK: begin
            if (is_peak && ((phase_now == PH_STARTED) || (mid > level))) begin
               phase_in      = PH_PEAK;
               peak_index_in = count_in;
               peak_level_in = newest;
               if (mid >= CMP_WIDTH'(thresholds.run_high)) begin
                  lower_limit_in  = thresholds.run_low;
                  motion_class_in = KIND_RUN;
               end else if (mid >= CMP_WIDTH'(thresholds.walk_high)) begin
                  lower_limit_in  = thresholds.walk_low;
                  motion_class_in = KIND_WALK;
               end else begin
                  lower_limit_in  = thresholds.slow_low;
                  motion_class_in = KIND_SLOW;
               end
            end
            // The end test sees the limit of a peak taken on this same word.
            if ((phase_now == PH_PEAK) && is_rise && (cur < CMP_WIDTH'(lower_limit_in))) begin
               done = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if ((cur > CMP_WIDTH'(thresholds.slow_low)) && is_rise) begin
               phase_in       = PH_STARTED;
               begin_index_in = end_index;
            end
         end
      endcase
      start_wide = 64'(begin_index_in);
      peak_wide  = 64'(peak_index_in);
      end_wide   = 64'(end_index);
      done_start = done ? start_wide[OUT_WIDTH-1:0] : '0;
      done_peak  = done ? peak_wide[OUT_WIDTH-1:0] : '0;
      done_end   = done ? end_wide[OUT_WIDTH-1:0] : '0;
      done_kind  = done ? motion_class_in : KIND_UNKNOWN;
      if (done) begin
         phase_in        = PH_IDLE;
         begin_index_in  = '0;
         peak_index_in   = '0;
         motion_class_in = KIND_UNKNOWN;
         lower_limit_in  = '0;
      end
   end

endmodule

// File: hdl/step_detector.sv
// Step detector for a stream of filtered acceleration-magnitude samples.
// The req_ channel carries one sample per word; the rsp_ channel returns
// exactly one result word per sample: step_done with the start, peak and
// end indices and the step kind, all zero when no step completed.
// Both channels use valid/ready. The six thresholds are written through
// csr_write_enable, csr_index and csr_write_data; the user must do so only
// while the block is idle; the block does not enforce it. Indices above five
// are ignored. A sample's result is registered onto rsp_ in the cycle after
// its acceptance. Throughput is one sample per cycle unless rsp_ stalls; the
// history, counter and step tracker update in one pass of compares and a
// few adds. The result register decouples the sides: a new sample is
// accepted while a result waits, provided rsp_ready takes the old one at
// the same edge. When the receiver stalls, req_ready drops and the result
// holds. Synchronous reset clears the history, the counter and the tracker
// and loads the default thresholds; no result is pending after reset.
module step_detector
   import sd_pkg::*;
#(
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [SAMPLE_WIDTH-1:0]     req_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_step_done,
   output logic [OUT_WIDTH-1:0]        rsp_step_start,
   output logic [OUT_WIDTH-1:0]        rsp_step_peak,
   output logic [OUT_WIDTH-1:0]        rsp_step_end,
   output logic [1:0]                  rsp_step_kind,
   input  logic                        csr_write_enable,
   input  logic [INDEX_WIDTH-1:0]      csr_index,
   input  logic [THRESHOLD_WIDTH-1:0]  csr_write_data
);

   thresholds_type              thresholds_ff;
   logic [SAMPLE_WIDTH-1:0]     newest_ff;
   logic [SAMPLE_WIDTH-1:0]     middle_ff;
   logic [COUNT_WIDTH-1:0]      count_ff;
   phase_type                   phase_ff;
   logic [COUNT_WIDTH-1:0]      begin_index_ff;
   logic [COUNT_WIDTH-1:0]      peak_index_ff;
   kind_type                    motion_class_ff;
   logic [THRESHOLD_WIDTH-1:0]  lower_limit_ff;
   logic [SAMPLE_WIDTH-1:0]     peak_level_ff;
   logic                        rsp_valid_ff;
   logic                        done_ff;
   logic [OUT_WIDTH-1:0]        start_ff;
   logic [OUT_WIDTH-1:0]        peak_ff;
   logic [OUT_WIDTH-1:0]        end_ff;
   kind_type                    kind_ff;

   logic [COUNT_WIDTH-1:0]      count_in;
   phase_type                   phase_in;
   logic [COUNT_WIDTH-1:0]      begin_index_in;
   logic [COUNT_WIDTH-1:0]      peak_index_in;
   kind_type                    motion_class_in;
   logic [THRESHOLD_WIDTH-1:0]  lower_limit_in;
   logic [SAMPLE_WIDTH-1:0]     peak_level_in;
   logic                        done_in;
   logic [OUT_WIDTH-1:0]        start_in;
   logic [OUT_WIDTH-1:0]        peak_in;
   logic [OUT_WIDTH-1:0]        end_in;
   kind_type                    kind_in;
   logic                        accept;

   assign req_ready      = !rsp_valid_ff || rsp_ready;
   assign accept         = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_done  = done_ff;
   assign rsp_step_start = start_ff;
   assign rsp_step_peak  = peak_ff;
   assign rsp_step_end   = end_ff;
   assign rsp_step_kind  = kind_ff;

   sd_step #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_step (
      .thresholds      (thresholds_ff),
      .sample          (req_sample),
      .newest          (newest_ff),
      .middle          (middle_ff),
      .count           (count_ff),
      .phase           (phase_ff),
      .begin_index     (begin_index_ff),
      .peak_index      (peak_index_ff),
      .motion_class    (motion_class_ff),
      .lower_limit     (lower_limit_ff),
      .peak_level      (peak_level_ff),
      .count_in        (count_in),
      .phase_in        (phase_in),
      .begin_index_in  (begin_index_in),
      .peak_index_in   (peak_index_in),
      .motion_class_in (motion_class_in),
      .lower_limit_in  (lower_limit_in),
      .peak_level_in   (peak_level_in),
      .done            (done_in),
      .done_start      (start_in),
      .done_peak       (peak_in),
      .done_end        (end_in),
      .done_kind       (kind_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thresholds_ff.slow_low  <= SLOW_LOW_RESET;
         thresholds_ff.slow_high <= SLOW_HIGH_RESET;
         thresholds_ff.walk_low  <= WALK_LOW_RESET;
         thresholds_ff.walk_high <= WALK_HIGH_RESET;
         thresholds_ff.run_low   <= RUN_LOW_RESET;
         thresholds_ff.run_high  <= RUN_HIGH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_SLOW_LOW:  thresholds_ff.slow_low  <= csr_write_data;
            REG_SLOW_HIGH: thresholds_ff.slow_high <= csr_write_data;
            REG_WALK_LOW:  thresholds_ff.walk_low  <= csr_write_data;
            REG_WALK_HIGH: thresholds_ff.walk_high <= csr_write_data;
            REG_RUN_LOW:   thresholds_ff.run_low   <= csr_write_data;
            REG_RUN_HIGH:  thresholds_ff.run_high  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff       <= '0;
         middle_ff       <= '0;
         count_ff        <= '0;
         phase_ff        <= PH_IDLE;
         begin_index_ff  <= '0;
         peak_index_ff   <= '0;
         motion_class_ff <= KIND_UNKNOWN;
         lower_limit_ff  <= '0;
         peak_level_ff   <= '0;
      end else if (accept) begin
         newest_ff       <= req_sample;
         middle_ff       <= newest_ff;
         count_ff        <= count_in;
         phase_ff        <= phase_in;
         begin_index_ff  <= begin_index_in;
         peak_index_ff   <= peak_index_in;
         motion_class_ff <= motion_class_in;
         lower_limit_ff  <= lower_limit_in;
         peak_level_ff   <= peak_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff  <= done_in;
         start_ff <= start_in;
         peak_ff  <= peak_in;
         end_ff   <= end_in;
         kind_ff  <= kind_in;
      end
   end

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("step tracker phase is not one-hot");

   a_peak_has_class: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PEAK) |-> (motion_class_ff != KIND_UNKNOWN))
      else $error("peak phase without a motion class");

   a_done_has_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> (kind_ff != KIND_UNKNOWN))
      else $error("completed step reported with unknown kind");

   a_idle_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !done_ff) |->
         ((start_ff == '0) && (peak_ff == '0) && (end_ff == '0) && (kind_ff == KIND_UNKNOWN)))
      else $error("result without a step carries nonzero fields");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

endmodule
